FILE: design/rbf_pkg.sv
// Shared types and codes of the ring buffer FIFO.
`default_nettype none
package rbf_pkg;

  localparam int MODE_W = 3;
  localparam int DATA_W = 8;
  localparam int CNT_W  = 5;
  localparam int STAT_W = 2;
  localparam int CFG_W  = 6;

  localparam logic [MODE_W-1:0] MODE_PUT   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_GET   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_PEEK  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_TAKE  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DROP  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_FLUSH = 3'd5;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_EMIT = 3'b100
  } ctrl_state_t;

  typedef struct packed {
    logic accept;
    logic read_step;
  } rbf_cmd_t;

  typedef struct packed {
    logic needs_read;
    logic last;
  } rbf_stat_t;

endpackage
`default_nettype wire

FILE: design/rbf_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rbf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

FILE: design/rbf_ctrl.sv
// Request sequencer of the ring buffer FIFO.
`default_nettype none
module rbf_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  output logic                    out_valid,
  input  wire logic               out_stall,
  input  wire rbf_pkg::rbf_stat_t stat,
  output rbf_pkg::rbf_cmd_t       cmd
);

  rbf_pkg::ctrl_state_t state_r, state_nxt;

  always_comb begin
    state_nxt     = state_r;
    in_stall      = 1'b1;
    out_valid     = 1'b0;
    cmd.accept    = 1'b0;
    cmd.read_step = 1'b0;
    case (state_r)
      rbf_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = stat.needs_read ? rbf_pkg::ST_READ : rbf_pkg::ST_EMIT;
        end
      end
      rbf_pkg::ST_READ: begin
        cmd.read_step = 1'b1;
        state_nxt     = rbf_pkg::ST_EMIT;
      end
      rbf_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_nxt = stat.last ? rbf_pkg::ST_IDLE : rbf_pkg::ST_READ;
        end
      end
      default: begin
        state_nxt = rbf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rbf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: design/rbf_dpath.sv
// Pointers, fill level, result registers and ring store of the FIFO.
`default_nettype none
module rbf_dpath #(
  parameter int DEPTH         = 32,
  parameter int ELEMENT_WIDTH = 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_wr_en,
  input  wire logic [rbf_pkg::CFG_W-1:0]   cfg_wr_data,
  input  wire logic [rbf_pkg::MODE_W-1:0]  in_mode,
  input  wire logic [rbf_pkg::DATA_W-1:0]  in_data_in,
  input  wire logic [rbf_pkg::CNT_W-1:0]   in_count,
  input  wire rbf_pkg::rbf_cmd_t           cmd,
  output rbf_pkg::rbf_stat_t               stat,
  output logic      [rbf_pkg::STAT_W-1:0]  out_status,
  output logic      [rbf_pkg::DATA_W-1:0]  out_data_out,
  output logic      [rbf_pkg::CNT_W-1:0]   out_done_count,
  output logic      [rbf_pkg::CNT_W-1:0]   out_fill_level,
  output logic                             out_last
);

  localparam int PTR_W    = $clog2(DEPTH);
  localparam int SZ_W     = PTR_W + 1;
  localparam int CNT_W    = rbf_pkg::CNT_W;
  localparam int DATA_W   = rbf_pkg::DATA_W;
  localparam int CFG_W    = rbf_pkg::CFG_W;
  localparam int CMP_W    = (SZ_W > CFG_W) ? SZ_W : CFG_W;
  localparam int NCMP_W   = (PTR_W > CNT_W) ? PTR_W : CNT_W;
  localparam int RST_SIZE = (DEPTH < 32) ? DEPTH : 32;

  logic [SZ_W-1:0]                 size_r, size_nxt;
  logic [PTR_W-1:0]                wp_r, wp_nxt;
  logic [PTR_W-1:0]                rp_r, rp_nxt;
  logic [PTR_W-1:0]                fill_r, fill_nxt;
  logic [PTR_W-1:0]                pos_r, pos_nxt;
  logic [PTR_W-1:0]                left_r, left_nxt;
  logic [PTR_W-1:0]                done_r, done_nxt;
  logic [rbf_pkg::STAT_W-1:0]      status_r, status_nxt;
  logic                            last_r, last_nxt;
  logic                            use_rd_r, use_rd_nxt;
  logic                            consume_r, consume_nxt;

  logic [CMP_W-1:0]                cfg_ext;
  logic [SZ_W-1:0]                 cfg_size;
  logic                            empty;
  logic                            full;
  logic [PTR_W-1:0]                n_req;
  logic [SZ_W-1:0]                 drop_sum;
  logic [PTR_W-1:0]                drop_rp;
  logic                            ram_wr_en;
  logic [ELEMENT_WIDTH-1:0]        ram_rd_data;

  function automatic logic [PTR_W-1:0] ring_inc(input logic [PTR_W-1:0] p,
                                                 input logic [SZ_W-1:0]  sz);
    logic [SZ_W-1:0] s;
    s        = SZ_W'(p) + SZ_W'(1);
    ring_inc = (s == sz) ? '0 : PTR_W'(s);
  endfunction

  always_comb begin
    cfg_ext = CMP_W'(cfg_wr_data);
    if (cfg_ext < CMP_W'(2)) begin
      cfg_size = SZ_W'(2);
    end else if (cfg_ext > CMP_W'(DEPTH)) begin
      cfg_size = SZ_W'(DEPTH);
    end else begin
      cfg_size = SZ_W'(cfg_ext);
    end
  end

  assign empty = (fill_r == '0);
  assign full  = (SZ_W'(fill_r) == size_r - SZ_W'(1));
  assign n_req = (NCMP_W'(in_count) < NCMP_W'(fill_r)) ? PTR_W'(in_count) : fill_r;

  always_comb begin
    drop_sum = SZ_W'(rp_r) + SZ_W'(n_req);
    drop_rp  = (drop_sum >= size_r) ? PTR_W'(drop_sum - size_r) : PTR_W'(drop_sum);
  end

  assign stat.needs_read = !empty &&
                           ((in_mode == rbf_pkg::MODE_GET) ||
                            (((in_mode == rbf_pkg::MODE_PEEK) ||
                              (in_mode == rbf_pkg::MODE_TAKE)) && (in_count != '0)));
  assign stat.last       = last_r;

  assign ram_wr_en = cmd.accept && (in_mode == rbf_pkg::MODE_PUT) && !full;

  always_comb begin
    size_nxt    = size_r;
    wp_nxt      = wp_r;
    rp_nxt      = rp_r;
    fill_nxt    = fill_r;
    pos_nxt     = pos_r;
    left_nxt    = left_r;
    done_nxt    = done_r;
    status_nxt  = status_r;
    last_nxt    = last_r;
    use_rd_nxt  = use_rd_r;
    consume_nxt = consume_r;
    if (cfg_wr_en) begin
      size_nxt = cfg_size;
      wp_nxt   = '0;
      rp_nxt   = '0;
      fill_nxt = '0;
    end else if (cmd.accept) begin
      status_nxt  = rbf_pkg::STAT_OK;
      done_nxt    = '0;
      last_nxt    = 1'b1;
      use_rd_nxt  = 1'b0;
      pos_nxt     = rp_r;
      left_nxt    = n_req;
      consume_nxt = (in_mode == rbf_pkg::MODE_TAKE);
      case (in_mode)
        rbf_pkg::MODE_PUT: begin
          if (full) begin
            status_nxt = rbf_pkg::STAT_FULL;
          end else begin
            wp_nxt   = ring_inc(wp_r, size_r);
            fill_nxt = fill_r + PTR_W'(1);
            done_nxt = PTR_W'(1);
          end
        end
        rbf_pkg::MODE_GET: begin
          consume_nxt = 1'b1;
          left_nxt    = PTR_W'(1);
          if (empty) begin
            status_nxt = rbf_pkg::STAT_EMPTY;
          end
        end
        rbf_pkg::MODE_PEEK, rbf_pkg::MODE_TAKE: begin
          if (empty) begin
            status_nxt = rbf_pkg::STAT_EMPTY;
          end
        end
        rbf_pkg::MODE_DROP: begin
          if (empty) begin
            status_nxt = rbf_pkg::STAT_EMPTY;
          end else begin
            rp_nxt   = drop_rp;
            fill_nxt = fill_r - n_req;
            done_nxt = n_req;
          end
        end
        rbf_pkg::MODE_FLUSH: begin
          wp_nxt   = '0;
          rp_nxt   = '0;
          fill_nxt = '0;
          done_nxt = fill_r;
        end
        default: begin
        end
      endcase
    end else if (cmd.read_step) begin
      // advance one element; the store returns it at the next edge
      use_rd_nxt = 1'b1;
      pos_nxt    = ring_inc(pos_r, size_r);
      done_nxt   = done_r + PTR_W'(1);
      left_nxt   = left_r - PTR_W'(1);
      last_nxt   = (left_r == PTR_W'(1));
      if (consume_r) begin
        rp_nxt   = ring_inc(pos_r, size_r);
        fill_nxt = fill_r - PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r    <= SZ_W'(RST_SIZE);
      wp_r      <= '0;
      rp_r      <= '0;
      fill_r    <= '0;
      last_r    <= 1'b1;
      consume_r <= 1'b0;
    end else begin
      size_r    <= size_nxt;
      wp_r      <= wp_nxt;
      rp_r      <= rp_nxt;
      fill_r    <= fill_nxt;
      last_r    <= last_nxt;
      consume_r <= consume_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r    <= pos_nxt;
    left_r   <= left_nxt;
    done_r   <= done_nxt;
    status_r <= status_nxt;
    use_rd_r <= use_rd_nxt;
  end

  rbf_ram #(
    .WIDTH (ELEMENT_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (wp_r),
    .wr_data (ELEMENT_WIDTH'(in_data_in)),
    .rd_en   (cmd.read_step),
    .rd_addr (pos_r),
    .rd_data (ram_rd_data)
  );

  assign out_status     = status_r;
  assign out_data_out   = use_rd_r ? DATA_W'(ram_rd_data) : '0;
  assign out_done_count = CNT_W'(done_r);
  assign out_fill_level = CNT_W'(fill_r);
  assign out_last       = last_r;

endmodule
`default_nettype wire

FILE: design/ring_buffer_fifo.sv
// Top level of the ring buffer FIFO.
//
// Ring buffer FIFO over a store of buffer_size slots (2..DEPTH, reset 32 or DEPTH if
// smaller), one slot kept empty, so at most buffer_size-1 words are held. Each input
// word is one request (put, get, peek n, take n, drop n, flush); every result word
// carries the fill level after it, and last marks the final result of a request.
// Requests are handled one at a time. Put, refused requests, drop, flush and unknown
// modes go from accept straight to the result. Get, and peek or take of n words, pass
// each word through the store's registered read port and then through the result
// register. An output stall holds the result word. Writing buffer_size clears both
// pointers; do it only while the FIFO is idle, as the block does not enforce it.
`default_nettype none
module ring_buffer_fifo #(
  parameter int DEPTH         = 32,
  parameter int ELEMENT_WIDTH = 8
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_wr_en,
  input  wire logic [rbf_pkg::CFG_W-1:0]  cfg_wr_data,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [rbf_pkg::MODE_W-1:0] in_mode,
  input  wire logic [rbf_pkg::DATA_W-1:0] in_data_in,
  input  wire logic [rbf_pkg::CNT_W-1:0]  in_count,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic      [rbf_pkg::STAT_W-1:0] out_status,
  output logic      [rbf_pkg::DATA_W-1:0] out_data_out,
  output logic      [rbf_pkg::CNT_W-1:0]  out_done_count,
  output logic      [rbf_pkg::CNT_W-1:0]  out_fill_level,
  output logic                            out_last
);

  rbf_pkg::rbf_cmd_t  cmd;
  rbf_pkg::rbf_stat_t stat;

  rbf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  rbf_dpath #(
    .DEPTH         (DEPTH),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_mode        (in_mode),
    .in_data_in     (in_data_in),
    .in_count       (in_count),
    .cmd            (cmd),
    .stat           (stat),
    .out_status     (out_status),
    .out_data_out   (out_data_out),
    .out_done_count (out_done_count),
    .out_fill_level (out_fill_level),
    .out_last       (out_last)
  );

endmodule
`default_nettype wire

FILE: design/rbf_checker.sv
// Port-level assertions of the ring buffer FIFO and their binding.
`default_nettype none
module rbf_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_stall,
  input wire logic                       out_valid,
  input wire logic                       out_stall,
  input wire logic [rbf_pkg::STAT_W-1:0] out_status,
  input wire logic [rbf_pkg::DATA_W-1:0] out_data_out,
  input wire logic [rbf_pkg::CNT_W-1:0]  out_done_count,
  input wire logic [rbf_pkg::CNT_W-1:0]  out_fill_level,
  input wire logic                       out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data_out) &&
      $stable(out_status) && $stable(out_done_count) && $stable(out_last))
    else $error("result word changed while stalled");

  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("new request taken before results delivered");

  a_more_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=> in_stall)
    else $error("request taken in the middle of a result run");

  a_refused: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != rbf_pkg::STAT_OK) |->
      out_last && (out_done_count == '0) && (out_data_out == '0))
    else $error("refused request with payload or run");

  a_empty_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == rbf_pkg::STAT_EMPTY) |-> (out_fill_level == '0))
    else $error("empty status with nonzero fill");

endmodule

bind ring_buffer_fifo rbf_checker u_rbf_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_status     (out_status),
  .out_data_out   (out_data_out),
  .out_done_count (out_done_count),
  .out_fill_level (out_fill_level),
  .out_last       (out_last)
);
`default_nettype wire

FILE: bench/tb.sv
// Testbench for the ring buffer FIFO: directed table, random traffic, predictor check.
`timescale 1ns / 100ps
module tb;

  localparam int MODE_W = rbf_pkg::MODE_W;
  localparam int DATA_W = rbf_pkg::DATA_W;
  localparam int CNT_W  = rbf_pkg::CNT_W;
  localparam int STAT_W = rbf_pkg::STAT_W;
  localparam int CFG_W  = rbf_pkg::CFG_W;
  localparam logic [MODE_W-1:0] MODE_NOP_A = 3'd6;
  localparam logic [MODE_W-1:0] MODE_NOP_B = 3'd7;
  localparam int RING_DEPTH = 32;
  localparam int PHASES = 8;
  localparam int PHASE_WORDS = 38;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [DATA_W-1:0] data;
    logic [CNT_W-1:0]  done;
    logic [CNT_W-1:0]  fill;
    logic              last;
  } reply_t;

  typedef struct packed {
    logic              is_cfg;
    logic [CFG_W-1:0]  size;
    logic [MODE_W-1:0] mode;
    logic [DATA_W-1:0] data;
    logic [CNT_W-1:0]  count;
    logic              typed;
    reply_t            reply;
  } row_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_PERIODIC,
    STALL_HEAVY
  } stall_kind_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]  cfg_wr_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [MODE_W-1:0] in_mode = '0;
  logic [DATA_W-1:0] in_data_in = '0;
  logic [CNT_W-1:0]  in_count = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [STAT_W-1:0] out_status;
  logic [DATA_W-1:0] out_data_out;
  logic [CNT_W-1:0]  out_done_count;
  logic [CNT_W-1:0]  out_fill_level;
  logic              out_last;

  logic [DATA_W-1:0] ring_mem [RING_DEPTH];
  int                wr_ptr;
  int                rd_ptr;
  int                ring_size;
  reply_t            step_replies [$];
  reply_t            pending_replies [$];
  row_t              directed_rows [$];
  int                errors = 0;
  int                burst_left = 0;
  int                stall_tick = 0;
  stall_kind_t       stall_kind = STALL_NONE;

  ring_buffer_fifo #(
    .DEPTH(RING_DEPTH),
    .ELEMENT_WIDTH(8)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_mode(in_mode),
    .in_data_in(in_data_in),
    .in_count(in_count),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_data_out(out_data_out),
    .out_done_count(out_done_count),
    .out_fill_level(out_fill_level),
    .out_last(out_last)
  );

  always #5 clk = ~clk;

  function automatic int clamp_size(logic [CFG_W-1:0] v);
    if (v < 2) return 2;
    if (v > RING_DEPTH) return RING_DEPTH;
    return int'(v);
  endfunction

  function automatic int fill_level();
    return (wr_ptr + ring_size - rd_ptr) % ring_size;
  endfunction

  function automatic void push_reply(logic [STAT_W-1:0] status, logic [DATA_W-1:0] data,
                                     int done, int fill, logic last);
    reply_t r;
    r.status = status;
    r.data = data;
    r.done = CNT_W'(done);
    r.fill = CNT_W'(fill);
    r.last = last;
    step_replies.push_back(r);
  endfunction

  function automatic void apply_request(logic [MODE_W-1:0] mode, logic [DATA_W-1:0] data,
                                        logic [CNT_W-1:0] count);
    int fill;
    int n;
    int pos;
    step_replies.delete();
    fill = fill_level();
    case (mode)
      rbf_pkg::MODE_PUT: begin
        if (fill == ring_size - 1) begin
          push_reply(rbf_pkg::STAT_FULL, '0, 0, fill, 1'b1);
        end else begin
          ring_mem[wr_ptr] = data;
          wr_ptr = (wr_ptr + 1) % ring_size;
          push_reply(rbf_pkg::STAT_OK, '0, 1, fill_level(), 1'b1);
        end
      end
      rbf_pkg::MODE_GET: begin
        if (fill == 0) begin
          push_reply(rbf_pkg::STAT_EMPTY, '0, 0, 0, 1'b1);
        end else begin
          pos = rd_ptr;
          rd_ptr = (rd_ptr + 1) % ring_size;
          push_reply(rbf_pkg::STAT_OK, ring_mem[pos], 1, fill_level(), 1'b1);
        end
      end
      rbf_pkg::MODE_PEEK, rbf_pkg::MODE_TAKE, rbf_pkg::MODE_DROP: begin
        n = (int'(count) < fill) ? int'(count) : fill;
        pos = rd_ptr;
        if (fill == 0) begin
          push_reply(rbf_pkg::STAT_EMPTY, '0, 0, 0, 1'b1);
        end else if (n == 0 || mode == rbf_pkg::MODE_DROP) begin
          if (mode == rbf_pkg::MODE_DROP) rd_ptr = (rd_ptr + n) % ring_size;
          push_reply(rbf_pkg::STAT_OK, '0, n, fill_level(), 1'b1);
        end else begin
          for (int k = 0; k < n; k++) begin
            data = ring_mem[pos];
            pos = (pos + 1) % ring_size;
            if (mode == rbf_pkg::MODE_TAKE) rd_ptr = pos;
            push_reply(rbf_pkg::STAT_OK, data, k + 1, fill_level(), k + 1 == n);
          end
        end
      end
      rbf_pkg::MODE_FLUSH: begin
        wr_ptr = 0;
        rd_ptr = 0;
        push_reply(rbf_pkg::STAT_OK, '0, fill, 0, 1'b1);
      end
      default: push_reply(rbf_pkg::STAT_OK, '0, 0, fill, 1'b1);
    endcase
  endfunction

  function automatic void add_req(logic [MODE_W-1:0] mode, logic [DATA_W-1:0] data,
                                  logic [CNT_W-1:0] count);
    row_t r;
    r = '0;
    r.mode = mode;
    r.data = data;
    r.count = count;
    directed_rows.push_back(r);
  endfunction

  function automatic void add_typed(logic [MODE_W-1:0] mode, logic [DATA_W-1:0] data,
                                    logic [CNT_W-1:0] count, logic [STAT_W-1:0] status,
                                    logic [DATA_W-1:0] dout, int done, int fill);
    row_t r;
    r = '0;
    r.mode = mode;
    r.data = data;
    r.count = count;
    r.typed = 1'b1;
    r.reply.status = status;
    r.reply.data = dout;
    r.reply.done = CNT_W'(done);
    r.reply.fill = CNT_W'(fill);
    r.reply.last = 1'b1;
    directed_rows.push_back(r);
  endfunction

  function automatic void add_cfg(logic [CFG_W-1:0] size);
    row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.size = size;
    directed_rows.push_back(r);
  endfunction

  task automatic send_word(logic [MODE_W-1:0] mode, logic [DATA_W-1:0] data,
                           logic [CNT_W-1:0] count, logic typed, reply_t typed_reply);
    in_valid <= 1'b1;
    in_mode <= mode;
    in_data_in <= data;
    in_count <= count;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    apply_request(mode, data, count);
    if (typed) begin
      pending_replies.push_back(typed_reply);
    end else begin
      foreach (step_replies[i]) pending_replies.push_back(step_replies[i]);
    end
  endtask

  task automatic pace();
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
    end else begin
      burst_left--;
    end
  endtask

  task automatic write_size(logic [CFG_W-1:0] size);
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= size;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    ring_size = clamp_size(size);
    wr_ptr = 0;
    rd_ptr = 0;
  endtask

  task automatic check_field(string name, int expected, int actual);
    if (expected != actual) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, expected, actual);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    stall_tick <= stall_tick + 1;
    if (stall_tick % 97 == 0) stall_kind <= stall_kind_t'($urandom_range(0, 3));
    case (stall_kind)
      STALL_NONE:     out_stall <= 1'b0;
      STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
      STALL_PERIODIC: out_stall <= (stall_tick % 3 == 0);
      default:        out_stall <= ($urandom_range(0, 9) < 7);
    endcase
  end

  always @(posedge clk) begin
    reply_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_replies.size() == 0) begin
        $display("%0t: result word with none expected, status %0d data %0d", $time,
                 out_status, out_data_out);
        errors++;
      end else begin
        want = pending_replies.pop_front();
        check_field("status", want.status, out_status);
        check_field("data_out", want.data, out_data_out);
        check_field("done_count", want.done, out_done_count);
        check_field("fill_level", want.fill, out_fill_level);
        check_field("last", want.last, out_last);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    int put_pct;
    int pick;
    logic [MODE_W-1:0] mode;
    logic [CNT_W-1:0] count;
    logic [CFG_W-1:0] phase_sizes [PHASES];
    phase_sizes = '{6'd3, 6'd32, 6'd1, 6'd5, 6'd40, 6'd17, 6'd2, 6'd31};
    foreach (ring_mem[i]) ring_mem[i] = '0;
    wr_ptr = 0;
    rd_ptr = 0;
    ring_size = clamp_size(6'd32);

    add_typed(rbf_pkg::MODE_GET,   8'h00, 5'd0,  rbf_pkg::STAT_EMPTY, 8'h00, 0, 0);
    add_typed(rbf_pkg::MODE_PEEK,  8'h00, 5'd31, rbf_pkg::STAT_EMPTY, 8'h00, 0, 0);
    add_typed(rbf_pkg::MODE_TAKE,  8'h00, 5'd5,  rbf_pkg::STAT_EMPTY, 8'h00, 0, 0);
    add_typed(rbf_pkg::MODE_DROP,  8'h00, 5'd0,  rbf_pkg::STAT_EMPTY, 8'h00, 0, 0);
    add_typed(rbf_pkg::MODE_PUT,   8'h00, 5'd0,  rbf_pkg::STAT_OK,    8'h00, 1, 1);
    add_typed(rbf_pkg::MODE_PUT,   8'hff, 5'd31, rbf_pkg::STAT_OK,    8'h00, 1, 2);
    add_typed(rbf_pkg::MODE_PUT,   8'ha5, 5'd0,  rbf_pkg::STAT_OK,    8'h00, 1, 3);
    add_typed(rbf_pkg::MODE_PEEK,  8'h00, 5'd0,  rbf_pkg::STAT_OK,    8'h00, 0, 3);
    add_req(rbf_pkg::MODE_PEEK, 8'h00, 5'd31);
    add_typed(MODE_NOP_A,          8'h00, 5'd0,  rbf_pkg::STAT_OK,    8'h00, 0, 3);
    add_typed(MODE_NOP_B,          8'hff, 5'd31, rbf_pkg::STAT_OK,    8'h00, 0, 3);
    add_typed(rbf_pkg::MODE_GET,   8'h00, 5'd0,  rbf_pkg::STAT_OK,    8'h00, 1, 2);
    add_typed(rbf_pkg::MODE_TAKE,  8'h00, 5'd1,  rbf_pkg::STAT_OK,    8'hff, 1, 1);
    add_req(rbf_pkg::MODE_PUT, 8'h5a, 5'd0);
    add_typed(rbf_pkg::MODE_DROP,  8'h00, 5'd31, rbf_pkg::STAT_OK,    8'h00, 2, 0);
    add_req(rbf_pkg::MODE_PUT, 8'h11, 5'd0);
    add_req(rbf_pkg::MODE_PUT, 8'h22, 5'd0);
    add_req(rbf_pkg::MODE_TAKE, 8'h00, 5'd31);
    add_req(rbf_pkg::MODE_PUT, 8'h33, 5'd0);
    add_req(rbf_pkg::MODE_PUT, 8'h44, 5'd0);
    add_typed(rbf_pkg::MODE_FLUSH, 8'h00, 5'd0,  rbf_pkg::STAT_OK,    8'h00, 2, 0);
    add_cfg(6'd0);
    add_typed(rbf_pkg::MODE_PUT,   8'h7f, 5'd0,  rbf_pkg::STAT_OK,    8'h00, 1, 1);
    add_typed(rbf_pkg::MODE_PUT,   8'h80, 5'd0,  rbf_pkg::STAT_FULL,  8'h00, 0, 1);
    add_typed(rbf_pkg::MODE_GET,   8'h00, 5'd0,  rbf_pkg::STAT_OK,    8'h7f, 1, 0);
    add_typed(rbf_pkg::MODE_FLUSH, 8'h00, 5'd0,  rbf_pkg::STAT_OK,    8'h00, 0, 0);
    add_cfg(6'd63);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        write_size(directed_rows[i].size);
      end else begin
        send_word(directed_rows[i].mode, directed_rows[i].data, directed_rows[i].count,
                  directed_rows[i].typed, directed_rows[i].reply);
        pace();
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      write_size(phase_sizes[ph]);
      put_pct = (ph % 2 == 0) ? $urandom_range(60, 90) : $urandom_range(25, 55);
      for (int j = 0; j < PHASE_WORDS; j++) begin
        pick = $urandom_range(0, 99);
        if (pick < put_pct) begin
          mode = rbf_pkg::MODE_PUT;
        end else begin
          pick = $urandom_range(0, 99);
          if (pick < 30)      mode = rbf_pkg::MODE_GET;
          else if (pick < 50) mode = rbf_pkg::MODE_PEEK;
          else if (pick < 75) mode = rbf_pkg::MODE_TAKE;
          else if (pick < 90) mode = rbf_pkg::MODE_DROP;
          else if (pick < 95) mode = rbf_pkg::MODE_FLUSH;
          else                mode = ($urandom_range(0, 1) == 0) ? MODE_NOP_A : MODE_NOP_B;
        end
        count = ($urandom_range(0, 9) < 7) ? CNT_W'($urandom_range(0, 4))
                                           : CNT_W'($urandom_range(0, 31));
        send_word(mode, DATA_W'($urandom_range(0, 255)), count, 1'b0, '0);
        pace();
      end
    end

    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
